@@ rtl/cbc_pkg.sv @@
`timescale 1ns / 1ps

package cbc_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    // address bits [15:13] select the bus window
    localparam logic [2:0] WIN_RAM_ENABLE = 3'd0;
    localparam logic [2:0] WIN_ROM_BANK   = 3'd1;
    localparam logic [2:0] WIN_RAM_BANK   = 3'd2;
    localparam logic [2:0] WIN_LATCH      = 3'd3;
    localparam logic [2:0] WIN_EXT_RAM    = 3'd5;

    localparam logic [7:0] RAM_ENABLE_KEY  = 8'hA0;
    localparam logic [7:0] RAM_DISABLE_KEY = 8'h00;
    localparam logic [7:0] LATCH_ARM_KEY   = 8'h00;
    localparam logic [7:0] LATCH_FIRE_KEY  = 8'h01;
    localparam logic [7:0] ROM_LIMIT_RESET = 8'd128;

    localparam logic [3:0] RTC_SECONDS = 4'h8;
    localparam logic [3:0] RTC_MINUTES = 4'h9;
    localparam logic [3:0] RTC_HOURS   = 4'hA;
    localparam logic [3:0] RTC_DAY_LOW = 4'hB;
    localparam logic [3:0] RTC_CONTROL = 4'hC;

    localparam logic [5:0] SECONDS_LAST = 6'd59;
    localparam logic [5:0] MINUTES_LAST = 6'd59;
    localparam logic [4:0] HOURS_LAST   = 5'd23;

    typedef struct packed {
        logic tick;
        logic latch;
    } rtc_ctrl_t;

    typedef struct packed {
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [7:0] day_low;
    } rtc_time_t;

endpackage

@@ rtl/cbc_rtc.sv @@
`timescale 1ns / 1ps

module cbc_rtc #(
    parameter int SECONDS_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cbc_pkg::rtc_ctrl_t ctrl,
    output cbc_pkg::rtc_time_t latched,
    output logic               day_over
);
    import cbc_pkg::*;

    localparam int DAY_W = SECONDS_WIDTH - 16;

    logic [SECONDS_WIDTH-1:0] count_reg, count_next;
    logic [5:0]               sec_reg, sec_next;
    logic [5:0]               min_reg, min_next;
    logic [4:0]               hour_reg, hour_next;
    logic [DAY_W-1:0]         day_reg, day_next;
    rtc_time_t                latched_reg, latched_next;

    // running count kept both in binary (for wrap) and split into time fields
    always_comb begin
        count_next   = count_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hour_next    = hour_reg;
        day_next     = day_reg;
        latched_next = latched_reg;
        if (ctrl.tick) begin
            count_next = count_reg + 1'b1;
            if (&count_reg) begin
                sec_next  = '0;
                min_next  = '0;
                hour_next = '0;
                day_next  = '0;
            end else if (sec_reg != SECONDS_LAST) begin
                sec_next = sec_reg + 1'b1;
            end else begin
                sec_next = '0;
                if (min_reg != MINUTES_LAST) begin
                    min_next = min_reg + 1'b1;
                end else begin
                    min_next = '0;
                    if (hour_reg != HOURS_LAST) begin
                        hour_next = hour_reg + 1'b1;
                    end else begin
                        hour_next = '0;
                        day_next  = day_reg + 1'b1;
                    end
                end
            end
        end
        if (ctrl.latch) begin
            latched_next.seconds = sec_reg;
            latched_next.minutes = min_reg;
            latched_next.hours   = hour_reg;
            latched_next.day_low = day_reg[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            sec_reg     <= '0;
            min_reg     <= '0;
            hour_reg    <= '0;
            day_reg     <= '0;
            latched_reg <= '0;
        end else begin
            count_reg   <= count_next;
            sec_reg     <= sec_next;
            min_reg     <= min_next;
            hour_reg    <= hour_next;
            day_reg     <= day_next;
            latched_reg <= latched_next;
        end
    end

    assign latched  = latched_reg;
    assign day_over = (day_reg >> 8) != '0;

endmodule

@@ rtl/cartridge_bank_controller_with_rtc.sv @@
`timescale 1ns / 1ps

// channel  direction  handshake          payload
// s_       in         s_valid/s_ready    s_op, s_address, s_write_data
// m_       out        m_valid/m_ready    m_handled, m_read_data, m_rom_bank,
//                                        m_ram_bank, m_ram_enabled, m_bank_error
// cfg_     in         cfg_wr_en          cfg_wr_data (ROM bank limit)
//
// One item per cycle sustained while m_ready is high; an item is held in the input
// register, then the result register, with all decode and register updates between the two.
// aresetn is synchronous and active low and resets all bank and clock state.
// A stalled m_ready holds the result and the input stage; s_ready drops only
// when both stages are full.

module cartridge_bank_controller_with_rtc #(
    parameter int SECONDS_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_handled,
    output logic [7:0]  m_read_data,
    output logic [6:0]  m_rom_bank,
    output logic [1:0]  m_ram_bank,
    output logic        m_ram_enabled,
    output logic        m_bank_error
);
    import cbc_pkg::*;

    logic [7:0]  rom_limit_reg;

    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;

    logic        ram_en_reg, ram_en_next;
    logic [6:0]  rom_bank_reg, rom_bank_next;
    logic [1:0]  ram_bank_reg, ram_bank_next;
    logic        clk_sel_reg, clk_sel_next;
    logic [3:0]  clk_index_reg, clk_index_next;
    logic        armed_reg, armed_next;
    logic [7:0]  day_ctrl_reg, day_ctrl_next;

    logic        out_valid_reg;
    logic        handled_reg, handled_next;
    logic [7:0]  rdata_reg, rdata_next;
    logic        err_reg, err_next;

    logic        advance;
    logic [2:0]  window;
    logic [3:0]  sel_code;
    rtc_ctrl_t   rtc_ctrl;
    rtc_time_t   rtc_time;
    logic        day_over;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign window  = addr_reg[15:13];
    assign sel_code = data_reg[3:0];

    cbc_rtc #(
        .SECONDS_WIDTH(SECONDS_WIDTH)
    ) u_rtc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rtc_ctrl),
        .latched (rtc_time),
        .day_over(day_over)
    );

    always_comb begin
        ram_en_next    = ram_en_reg;
        rom_bank_next  = rom_bank_reg;
        ram_bank_next  = ram_bank_reg;
        clk_sel_next   = clk_sel_reg;
        clk_index_next = clk_index_reg;
        armed_next     = armed_reg;
        day_ctrl_next  = day_ctrl_reg;
        handled_next   = 1'b0;
        rdata_next     = '0;
        err_next       = 1'b0;
        rtc_ctrl       = '0;
        if (advance) begin
            unique case (op_reg)
                OP_WRITE: begin
                    unique case (window)
                        WIN_RAM_ENABLE: begin
                            if (data_reg == RAM_ENABLE_KEY) begin
                                ram_en_next = 1'b1;
                            end else if (data_reg == RAM_DISABLE_KEY) begin
                                ram_en_next = 1'b0;
                            end
                            handled_next = 1'b1;
                        end
                        WIN_ROM_BANK: begin
                            // zero maps to bank one before the mask
                            rom_bank_next = (data_reg == '0) ? 7'd1 : data_reg[6:0];
                            err_next      = {1'b0, rom_bank_next} >= rom_limit_reg;
                            handled_next  = 1'b1;
                        end
                        WIN_RAM_BANK: begin
                            if (sel_code[3:2] == 2'b00) begin
                                clk_sel_next  = 1'b0;
                                ram_bank_next = sel_code[1:0];
                            end else begin
                                clk_sel_next   = 1'b1;
                                clk_index_next = sel_code;
                            end
                            handled_next = 1'b1;
                        end
                        WIN_LATCH: begin
                            if (clk_sel_reg) begin
                                if (data_reg == LATCH_ARM_KEY && !armed_reg) begin
                                    armed_next = 1'b1;
                                end else if (data_reg == LATCH_FIRE_KEY && armed_reg) begin
                                    armed_next       = 1'b0;
                                    rtc_ctrl.latch   = 1'b1;
                                    day_ctrl_next[0] = day_over;
                                end
                                handled_next = 1'b1;
                            end
                        end
                        WIN_EXT_RAM: begin
                            if (clk_sel_reg) begin
                                if (clk_index_reg == RTC_CONTROL) begin
                                    day_ctrl_next = data_reg;
                                end
                                handled_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_READ: begin
                    if (window == WIN_EXT_RAM && clk_sel_reg) begin
                        handled_next = 1'b1;
                        unique case (clk_index_reg)
                            RTC_SECONDS: rdata_next = {2'b00, rtc_time.seconds};
                            RTC_MINUTES: rdata_next = {2'b00, rtc_time.minutes};
                            RTC_HOURS:   rdata_next = {3'b000, rtc_time.hours};
                            RTC_DAY_LOW: rdata_next = rtc_time.day_low;
                            RTC_CONTROL: rdata_next = day_ctrl_reg;
                            default:     rdata_next = '0;
                        endcase
                    end
                end
                OP_TICK: rtc_ctrl.tick = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_limit_reg <= ROM_LIMIT_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ram_en_reg    <= 1'b1;
            rom_bank_reg  <= 7'd1;
            ram_bank_reg  <= '0;
            clk_sel_reg   <= 1'b0;
            clk_index_reg <= RTC_SECONDS;
            armed_reg     <= 1'b0;
            day_ctrl_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                rom_limit_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            ram_en_reg    <= ram_en_next;
            rom_bank_reg  <= rom_bank_next;
            ram_bank_reg  <= ram_bank_next;
            clk_sel_reg   <= clk_sel_next;
            clk_index_reg <= clk_index_next;
            armed_reg     <= armed_next;
            day_ctrl_reg  <= day_ctrl_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            op_reg   <= s_op;
            addr_reg <= s_address;
            data_reg <= s_write_data;
        end
        if (advance) begin
            handled_reg <= handled_next;
            rdata_reg   <= rdata_next;
            err_reg     <= err_next;
        end
    end

    // bank state only changes on advance, so it tracks the held result
    assign m_valid       = out_valid_reg;
    assign m_handled     = handled_reg;
    assign m_read_data   = rdata_reg;
    assign m_rom_bank    = rom_bank_reg;
    assign m_ram_bank    = ram_bank_reg;
    assign m_ram_enabled = ram_en_reg;
    assign m_bank_error  = err_reg;

endmodule

@@ verif/cbc_bus_checker.sv @@
`timescale 1ns / 1ps

module cbc_bus_checker #(
    parameter int SECONDS_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_write_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_handled,
    input  logic [7:0]  m_read_data,
    input  logic [6:0]  m_rom_bank,
    input  logic [1:0]  m_ram_bank,
    input  logic        m_ram_enabled,
    input  logic        m_bank_error,
    output int          mismatches,
    output int          pending,
    output int          results_checked
);
    import cbc_pkg::*;

    localparam int unsigned MINUTE_SECONDS = 60;
    localparam int unsigned HOUR_SECONDS   = 3600;
    localparam int unsigned DAY_SECONDS    = 86400;

    typedef struct packed {
        logic       handled;
        logic [7:0] read_data;
        logic [6:0] rom_bank;
        logic [1:0] ram_bank;
        logic       ram_enabled;
        logic       bank_error;
    } bank_result_t;

    bank_result_t expected_results [$];

    logic [7:0]               bank_limit;
    logic                     ram_on;
    logic [6:0]               rom_sel;
    logic [1:0]               ram_sel;
    logic                     clock_sel;
    logic [3:0]               rtc_index;
    logic                     latch_armed;
    logic [SECONDS_WIDTH-1:0] running_count;
    logic [SECONDS_WIDTH-1:0] latched_count;
    logic [7:0]               day_ctrl;

    function automatic logic [7:0] rtc_register();
        logic [SECONDS_WIDTH-1:0] q;
        q = '0;
        case (rtc_index)
            RTC_SECONDS: q = latched_count % MINUTE_SECONDS;
            RTC_MINUTES: q = (latched_count / MINUTE_SECONDS) % 60;
            RTC_HOURS:   q = (latched_count / HOUR_SECONDS) % 24;
            RTC_DAY_LOW: q = latched_count / DAY_SECONDS;
            RTC_CONTROL: q = SECONDS_WIDTH'(day_ctrl);
            default:     q = '0;
        endcase
        return q[7:0];
    endfunction

    function automatic bank_result_t decode_access(input logic [1:0] op_bits,
                                                   input logic [15:0] addr,
                                                   input logic [7:0] data);
        bank_result_t r;
        logic [7:0]   d;
        op_t          op;
        r  = '0;
        d  = data;
        op = op_t'(op_bits);
        case (op)
            OP_WRITE: begin
                case (addr[15:13])
                    WIN_RAM_ENABLE: begin
                        if (d == RAM_ENABLE_KEY) begin
                            ram_on = 1'b1;
                        end else if (d == RAM_DISABLE_KEY) begin
                            ram_on = 1'b0;
                        end
                        r.handled = 1'b1;
                    end
                    WIN_ROM_BANK: begin
                        if (d == 8'h00) begin
                            d = 8'h01;
                        end
                        rom_sel = d[6:0];
                        r.bank_error = ({1'b0, rom_sel} >= bank_limit);
                        r.handled = 1'b1;
                    end
                    WIN_RAM_BANK: begin
                        if (d[3:0] <= 4'd3) begin
                            clock_sel = 1'b0;
                            ram_sel = d[1:0];
                        end else begin
                            clock_sel = 1'b1;
                            rtc_index = d[3:0];
                        end
                        r.handled = 1'b1;
                    end
                    WIN_LATCH: begin
                        if (clock_sel) begin
                            if (d == LATCH_ARM_KEY && !latch_armed) begin
                                latch_armed = 1'b1;
                            end else if (d == LATCH_FIRE_KEY && latch_armed) begin
                                latch_armed = 1'b0;
                                latched_count = running_count;
                                day_ctrl[0] = ((latched_count / DAY_SECONDS) > 255);
                            end
                            r.handled = 1'b1;
                        end
                    end
                    WIN_EXT_RAM: begin
                        if (clock_sel) begin
                            if (rtc_index == RTC_CONTROL) begin
                                day_ctrl = d;
                            end
                            r.handled = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_READ: begin
                if (addr[15:13] == WIN_EXT_RAM && clock_sel) begin
                    r.handled = 1'b1;
                    r.read_data = rtc_register();
                end
            end
            OP_TICK: begin
                running_count = running_count + 1'b1;
            end
            default: ;
        endcase
        r.rom_bank    = rom_sel;
        r.ram_bank    = ram_sel;
        r.ram_enabled = ram_on;
        return r;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endfunction

    initial begin
        mismatches      = 0;
        pending         = 0;
        results_checked = 0;
    end

    always @(posedge aclk) begin
        bank_result_t want;
        if (!aresetn) begin
            bank_limit    = ROM_LIMIT_RESET;
            ram_on        = 1'b1;
            rom_sel       = 7'd1;
            ram_sel       = 2'd0;
            clock_sel     = 1'b0;
            rtc_index     = RTC_SECONDS;
            latch_armed   = 1'b0;
            running_count = '0;
            latched_count = '0;
            day_ctrl      = 8'h00;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                bank_limit = cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result with no item outstanding", $time);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    check_field("handled", want.handled, m_handled);
                    check_field("read_data", want.read_data, m_read_data);
                    check_field("rom_bank", want.rom_bank, m_rom_bank);
                    check_field("ram_bank", want.ram_bank, m_ram_bank);
                    check_field("ram_enabled", want.ram_enabled, m_ram_enabled);
                    check_field("bank_error", want.bank_error, m_bank_error);
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(decode_access(s_op, s_address, s_write_data));
            end
        end
        pending = expected_results.size();
    end

endmodule

@@ verif/cartridge_bank_controller_with_rtc_tb.sv @@
`timescale 1ns / 1ps

module cartridge_bank_controller_with_rtc_tb;
    import cbc_pkg::*;

    localparam int TICK_RUN    = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 150;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_op;
    logic [15:0] s_address;
    logic [7:0]  s_write_data;
    logic        m_valid;
    logic        m_ready;
    logic        m_handled;
    logic [7:0]  m_read_data;
    logic [6:0]  m_rom_bank;
    logic [1:0]  m_ram_bank;
    logic        m_ram_enabled;
    logic        m_bank_error;

    int mismatches;
    int pending;
    int results_checked;
    int items_sent;
    int ticks_sent;
    int limit_writes;
    bit calm;
    bit squeeze;
    bit hold_done;

    cartridge_bank_controller_with_rtc i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_address     (s_address),
        .s_write_data  (s_write_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_handled     (m_handled),
        .m_read_data   (m_read_data),
        .m_rom_bank    (m_rom_bank),
        .m_ram_bank    (m_ram_bank),
        .m_ram_enabled (m_ram_enabled),
        .m_bank_error  (m_bank_error)
    );

    cbc_bus_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_address       (s_address),
        .s_write_data    (s_write_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_handled       (m_handled),
        .m_read_data     (m_read_data),
        .m_rom_bank      (m_rom_bank),
        .m_ram_bank      (m_ram_bank),
        .m_ram_enabled   (m_ram_enabled),
        .m_bank_error    (m_bank_error),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [15:0] window_addr(input logic [2:0] win);
        logic [15:0] a;
        a = 16'($urandom);
        a[15:13] = win;
        return a;
    endfunction

    task automatic push_access(input logic [1:0] op, input logic [15:0] addr,
                               input logic [7:0] data);
        if (!calm && $urandom_range(0, 7) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_op         <= op;
        s_address    <= addr;
        s_write_data <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (op == OP_TICK) begin
            ticks_sent++;
        end
    endtask

    task automatic write_limit(input logic [7:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        limit_writes++;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic random_access();
        int unsigned pick;
        logic [7:0]  d;
        pick = $urandom_range(0, 99);
        d = 8'($urandom);
        if (pick < 24) begin
            push_access(OP_TICK, 16'($urandom), d);
        end else if (pick < 32) begin
            case ($urandom_range(0, 2))
                0:       d = RAM_ENABLE_KEY;
                1:       d = RAM_DISABLE_KEY;
                default: ;
            endcase
            push_access(OP_WRITE, window_addr(WIN_RAM_ENABLE), d);
        end else if (pick < 42) begin
            case ($urandom_range(0, 3))
                0:       d = 8'h00;
                1:       d = 8'h80;
                2:       d = 8'($urandom_range(0, 3));
                default: ;
            endcase
            push_access(OP_WRITE, window_addr(WIN_ROM_BANK), d);
        end else if (pick < 52) begin
            if ($urandom_range(0, 1) == 1) begin
                d[3:0] = 4'($urandom_range(8, 12));
            end
            push_access(OP_WRITE, window_addr(WIN_RAM_BANK), d);
        end else if (pick < 62) begin
            case ($urandom_range(0, 2))
                0:       d = LATCH_ARM_KEY;
                1:       d = LATCH_FIRE_KEY;
                default: ;
            endcase
            push_access(OP_WRITE, window_addr(WIN_LATCH), d);
        end else if (pick < 74) begin
            push_access(OP_READ, window_addr(WIN_EXT_RAM), d);
        end else if (pick < 79) begin
            push_access(OP_WRITE, window_addr(WIN_EXT_RAM), d);
        end else if (pick < 88) begin
            d[3:0] = 4'($urandom_range(8, 12));
            push_access(OP_WRITE, window_addr(WIN_RAM_BANK), d);
            push_access(OP_WRITE, window_addr(WIN_LATCH), LATCH_ARM_KEY);
            push_access(OP_WRITE, window_addr(WIN_LATCH), LATCH_FIRE_KEY);
            push_access(OP_READ, window_addr(WIN_EXT_RAM), 8'($urandom));
        end else begin
            push_access(2'($urandom), 16'($urandom), d);
        end
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        hold_done  = 1'b0;
        m_ready   <= 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (squeeze && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
                m_ready  <= 1'b1;
            end else if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 16);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int          target;
        int          guard;
        logic [7:0]  lim;
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= 8'h00;
        s_valid      <= 1'b0;
        s_op         <= OP_WRITE;
        s_address    <= 16'h0000;
        s_write_data <= 8'h00;
        items_sent   = 0;
        ticks_sent   = 0;
        limit_writes = 0;
        calm         = 1'b0;
        squeeze      = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        write_limit(ROM_LIMIT_RESET);

        push_access(OP_READ, 16'hA000, 8'h00);
        push_access(OP_WRITE, 16'h0000, RAM_DISABLE_KEY);
        push_access(OP_WRITE, 16'h1FFF, RAM_ENABLE_KEY);
        push_access(OP_WRITE, 16'h0ABC, 8'h55);
        push_access(OP_WRITE, 16'h2000, 8'h00);
        push_access(OP_WRITE, 16'h3FFF, 8'h80);
        push_access(OP_WRITE, 16'h2000, 8'h7F);
        push_access(OP_WRITE, 16'h2ABC, 8'hFF);
        push_access(OP_WRITE, 16'h4000, 8'h03);
        push_access(OP_WRITE, 16'h5FFF, {4'h0, RTC_SECONDS});
        push_access(OP_WRITE, 16'h6000, LATCH_FIRE_KEY);
        push_access(OP_WRITE, 16'h6000, LATCH_ARM_KEY);
        push_access(OP_WRITE, 16'h6000, LATCH_ARM_KEY);
        push_access(OP_TICK, 16'hFFFF, 8'hFF);
        push_access(OP_TICK, 16'h0000, 8'h00);
        push_access(OP_WRITE, 16'h7FFF, LATCH_FIRE_KEY);
        push_access(OP_READ, 16'hBFFF, 8'hFF);
        push_access(OP_WRITE, 16'h4000, {4'h0, RTC_CONTROL});
        push_access(OP_WRITE, 16'hBFFF, 8'h40);
        push_access(OP_READ, 16'hA123, 8'h00);
        push_access(OP_WRITE, 16'h4000, 8'h0D);
        push_access(OP_WRITE, 16'hA000, 8'hFF);
        push_access(OP_READ, 16'hA000, 8'h00);
        push_access(OP_WRITE, 16'h4000, 8'hF4);
        push_access(OP_READ, 16'hB000, 8'h00);
        push_access(OP_WRITE, 16'h8000, 8'hA0);
        push_access(OP_WRITE, 16'hFFFF, 8'hFF);
        push_access(2'd3, 16'hFFFF, 8'hFF);
        push_access(OP_WRITE, 16'h4000, 8'h00);
        push_access(OP_WRITE, 16'h6000, LATCH_ARM_KEY);
        push_access(OP_WRITE, 16'hA000, 8'h12);

        // advance the seconds counter, then latch and read every register
        calm = 1'b1;
        push_access(OP_WRITE, 16'h4000, {4'h0, RTC_SECONDS});
        repeat (TICK_RUN) push_access(OP_TICK, 16'($urandom), 8'($urandom));
        push_access(OP_WRITE, 16'h6000, LATCH_ARM_KEY);
        push_access(OP_WRITE, 16'h6000, LATCH_FIRE_KEY);
        for (int idx = RTC_SECONDS; idx <= RTC_CONTROL; idx++) begin
            push_access(OP_WRITE, 16'h4000, 8'(idx));
            push_access(OP_READ, window_addr(WIN_EXT_RAM), 8'h00);
        end
        calm = 1'b0;

        for (int phase = 0; phase < 5; phase++) begin
            settle();
            case (phase)
                0:       lim = 8'd2;
                1:       lim = 8'd128;
                2:       lim = 8'd127;
                default: lim = 8'($urandom_range(2, 128));
            endcase
            write_limit(lim);
            if (phase == 0) begin
                calm    = 1'b1;
                squeeze = 1'b1;
                repeat (30) random_access();
                calm    = 1'b0;
            end
            if (phase == 4) begin
                calm = 1'b1;
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) random_access();
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 20000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);

        $display("covered %0d bus items over %0d ROM bank limit settings, %0d results checked",
                 items_sent, limit_writes, results_checked);
        $display("seconds counter advanced %0d ticks, latch, clock reads and bank faults included",
                 ticks_sent);
        if (pending != 0) begin
            $display("%0d expected results never arrived", pending);
        end
        if (mismatches == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ cartridge_bank_controller_with_rtc.f @@
rtl/cbc_pkg.sv
rtl/cbc_rtc.sv
rtl/cartridge_bank_controller_with_rtc.sv
verif/cbc_bus_checker.sv
verif/cartridge_bank_controller_with_rtc_tb.sv
